>>> rtl/utf8v_pkg.sv
// Shared types and codes for the UTF-8 string byte validator.
package utf8v_pkg;

   // Result status codes
   localparam logic [1:0] ST_PENDING  = 2'd0;
   localparam logic [1:0] ST_COMPLETE = 2'd1;
   localparam logic [1:0] ST_ERROR    = 2'd2;

   // Allowed range of the first continuation byte
   typedef enum logic [2:0] {
      RANGE_80_BF = 3'd0,
      RANGE_A0_BF = 3'd1,
      RANGE_80_9F = 3'd2,
      RANGE_90_BF = 3'd3,
      RANGE_80_8F = 3'd4
   } cont_range_type;

   // Sequence tracking state carried between bytes
   typedef struct packed {
      logic [1:0]     bytes_owed;
      cont_range_type first_cont_range;
      logic           need_first_check;
      logic [2:0]     seq_length;
   } seq_state_type;

   // One result beat
   typedef struct packed {
      logic [1:0] status;
      logic [2:0] char_length;
   } result_type;

   localparam seq_state_type SEQ_IDLE = '{
      bytes_owed:       2'd0,
      first_cont_range: RANGE_80_BF,
      need_first_check: 1'b0,
      seq_length:       3'd0
   };

endpackage

>>> rtl/utf8v_step.sv
// Per-byte decision logic: classify a byte against the sequence state.
module utf8v_step (
   input  logic [7:0]               byte_value,
   input  logic                     is_last,
   input  utf8v_pkg::seq_state_type state_cur,
   output utf8v_pkg::seq_state_type state_nxt,
   output utf8v_pkg::result_type    result
);

   localparam logic [7:0] CTRL_LIMIT = 8'h20;
   localparam logic [7:0] ASCII_MAX  = 8'h7f;
   localparam logic [7:0] LEAD2_MIN  = 8'hc2;
   localparam logic [7:0] LEAD2_MAX  = 8'hdf;
   localparam logic [7:0] LEAD3_MIN  = 8'he0;
   localparam logic [7:0] LEAD3_MAX  = 8'hef;
   localparam logic [7:0] LEAD3_SURR = 8'hed;
   localparam logic [7:0] LEAD4_MIN  = 8'hf0;
   localparam logic [7:0] LEAD4_MAX  = 8'hf4;

   utf8v_pkg::cont_range_type rng_use;
   logic                      cont_ok;
   logic [1:0]                owed_dec;

   // Pick the range check for a continuation byte
   always_comb begin
      rng_use = state_cur.need_first_check ? state_cur.first_cont_range
                                           : utf8v_pkg::RANGE_80_BF;
      unique case (rng_use)
         utf8v_pkg::RANGE_A0_BF: cont_ok = (byte_value >= 8'ha0) && (byte_value <= 8'hbf);
         utf8v_pkg::RANGE_80_9F: cont_ok = (byte_value >= 8'h80) && (byte_value <= 8'h9f);
         utf8v_pkg::RANGE_90_BF: cont_ok = (byte_value >= 8'h90) && (byte_value <= 8'hbf);
         utf8v_pkg::RANGE_80_8F: cont_ok = (byte_value >= 8'h80) && (byte_value <= 8'h8f);
         default:                cont_ok = (byte_value[7:6] == 2'b10);
      endcase
   end

   assign owed_dec = state_cur.bytes_owed - 2'd1;

   // Decide result and next state
   always_comb begin
      state_nxt          = utf8v_pkg::SEQ_IDLE;
      result.status      = utf8v_pkg::ST_ERROR;
      result.char_length = 3'd0;
      if (state_cur.bytes_owed == 2'd0) begin
         // lead byte
         priority if (byte_value < CTRL_LIMIT) begin
            result.status = utf8v_pkg::ST_ERROR;
         end else if (byte_value <= ASCII_MAX) begin
            result.status      = utf8v_pkg::ST_COMPLETE;
            result.char_length = 3'd1;
         end else if ((byte_value >= LEAD2_MIN) && (byte_value <= LEAD2_MAX) && !is_last) begin
            result.status              = utf8v_pkg::ST_PENDING;
            state_nxt.bytes_owed       = 2'd1;
            state_nxt.need_first_check = 1'b1;
            state_nxt.seq_length       = 3'd2;
         end else if ((byte_value >= LEAD3_MIN) && (byte_value <= LEAD3_MAX) && !is_last) begin
            result.status              = utf8v_pkg::ST_PENDING;
            state_nxt.bytes_owed       = 2'd2;
            state_nxt.need_first_check = 1'b1;
            state_nxt.seq_length       = 3'd3;
            if (byte_value == LEAD3_MIN) begin
               state_nxt.first_cont_range = utf8v_pkg::RANGE_A0_BF;
            end else if (byte_value == LEAD3_SURR) begin
               state_nxt.first_cont_range = utf8v_pkg::RANGE_80_9F;
            end
         end else if ((byte_value >= LEAD4_MIN) && (byte_value <= LEAD4_MAX) && !is_last) begin
            result.status              = utf8v_pkg::ST_PENDING;
            state_nxt.bytes_owed       = 2'd3;
            state_nxt.need_first_check = 1'b1;
            state_nxt.seq_length       = 3'd4;
            if (byte_value == LEAD4_MIN) begin
               state_nxt.first_cont_range = utf8v_pkg::RANGE_90_BF;
            end else if (byte_value == LEAD4_MAX) begin
               state_nxt.first_cont_range = utf8v_pkg::RANGE_80_8F;
            end
         end else begin
            // invalid lead, or a multi-byte lead cut off by the string end
            result.status = utf8v_pkg::ST_ERROR;
         end
      end else begin
         // continuation byte
         priority if (!cont_ok) begin
            result.status = utf8v_pkg::ST_ERROR;
         end else if (owed_dec == 2'd0) begin
            result.status      = utf8v_pkg::ST_COMPLETE;
            result.char_length = state_cur.seq_length;
         end else if (is_last) begin
            result.status = utf8v_pkg::ST_ERROR;
         end else begin
            result.status              = utf8v_pkg::ST_PENDING;
            state_nxt                  = state_cur;
            state_nxt.bytes_owed       = owed_dec;
            state_nxt.need_first_check = 1'b0;
         end
      end
   end

endmodule

>>> rtl/utf8_string_byte_validator.sv
// Top level: input register, per-byte decision and result register.
//
//   channel | direction | ports                                  | handshake
//   req     | in        | req_byte_value, req_is_last            | req_valid / req_stall
//   rsp     | out       | rsp_status, rsp_char_length            | rsp_valid / rsp_stall
//
// One byte per cycle while rsp_stall is low; each beat passes from req to rsp
// through the input register, then the result register behind the state-dependent decision.
// The sequence state updates as a byte moves from the input register to the
// result register, so consecutive bytes chain without bubbles.
// Reset clears the sequence state and both valid flags.
// rsp_stall holds the result register; req_stall rises only when the input
// register is full and cannot move forward.
module utf8_string_byte_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_value,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [2:0] rsp_char_length
);

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff;
   logic                     in_last_ff;
   logic                     out_valid_ff, out_valid_in;
   utf8v_pkg::result_type    out_result_ff;
   utf8v_pkg::seq_state_type state_ff;
   utf8v_pkg::seq_state_type state_in;
   utf8v_pkg::result_type    step_result;
   logic                     out_free;
   logic                     in_move;
   logic                     req_take;

   // Stage flow control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_move   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !in_move);
   assign out_valid_in = in_move || (out_valid_ff && !out_free);

   utf8v_step u_step (
      .byte_value (in_byte_ff),
      .is_last    (in_last_ff),
      .state_cur  (state_ff),
      .state_nxt  (state_in),
      .result     (step_result)
   );

   // Advance valid flags and sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= utf8v_pkg::SEQ_IDLE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (in_move) begin
            state_ff <= state_in;
         end
      end
   end

   // Capture input beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_byte_value;
         in_last_ff <= req_is_last;
      end
   end

   // Capture result beat
   always_ff @(posedge clock) begin
      if (in_move) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_result_ff.status;
   assign rsp_char_length = out_result_ff.char_length;

endmodule

>>> rtl/utf8v_checker.sv
// Port-level checks for the UTF-8 string byte validator, bound to the top level.
module utf8v_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_byte_value,
   input logic       req_is_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic [2:0] rsp_char_length
);

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Status is a defined code and length follows it
   a_len_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == utf8v_pkg::ST_COMPLETE) &&
                     (rsp_char_length != 3'd0) && (rsp_char_length <= 3'd4)) ||
                    (((rsp_status == utf8v_pkg::ST_PENDING) ||
                      (rsp_status == utf8v_pkg::ST_ERROR)) && (rsp_char_length == 3'd0)))
      else $error("bad status or char_length on rsp");

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
                                    $stable(rsp_char_length)))
      else $error("stalled rsp beat changed");

   // Hold a stalled request beat
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_byte_value) &&
                                    $stable(req_is_last)))
      else $error("stalled req beat changed");

   // Keep input ready when the result side drains
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("req stalled while output free");

endmodule

bind utf8_string_byte_validator utf8v_checker u_utf8v_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_byte_value  (req_byte_value),
   .req_is_last     (req_is_last),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_char_length (rsp_char_length)
);

>>> sim/tb_utf8_string_byte_validator.sv
// Testbench for the UTF-8 string byte validator: directed boundary bytes, random strings.
module tb_utf8_string_byte_validator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_byte_value;
   logic       req_is_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_status;
   logic [2:0] rsp_char_length;

   // Scoreboard and traffic shaping
   utf8v_pkg::result_type pending_verdicts[$];
   logic [7:0] string_bytes[$];
   int         req_idle_pct  = 0;
   int         rsp_idle_pct  = 0;
   int         hold_left     = 0;
   int         fail_count    = 0;
   int         cycle_count   = 0;
   int         bytes_sent    = 0;
   int         chars_done    = 0;
   int         bytes_bad     = 0;
   int         bytes_waiting = 0;

   // Shadow copy of the sequence tracker
   logic [1:0]                owed_count    = 2'd0;
   utf8v_pkg::cont_range_type lead_range    = utf8v_pkg::RANGE_80_BF;
   logic                      first_pending = 1'b0;
   logic [2:0]                char_bytes    = 3'd0;

   utf8_string_byte_validator u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_value  (req_byte_value),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_char_length (rsp_char_length)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Judge one byte against the tracker and advance it
   function automatic utf8v_pkg::result_type judge_byte(input logic [7:0] b, input logic last);
      utf8v_pkg::result_type     verdict;
      logic [1:0]                lead_owed;
      utf8v_pkg::cont_range_type lead_rng;
      utf8v_pkg::cont_range_type rng;
      logic                      in_range;
      verdict.status      = utf8v_pkg::ST_PENDING;
      verdict.char_length = 3'd0;
      if (owed_count == 2'd0) begin
         lead_owed = 2'd0;
         lead_rng  = utf8v_pkg::RANGE_80_BF;
         if (b >= 8'hc2 && b <= 8'hdf) begin
            lead_owed = 2'd1;
         end else if (b >= 8'he0 && b <= 8'hef) begin
            lead_owed = 2'd2;
            if (b == 8'he0) lead_rng = utf8v_pkg::RANGE_A0_BF;
            else if (b == 8'hed) lead_rng = utf8v_pkg::RANGE_80_9F;
         end else if (b >= 8'hf0 && b <= 8'hf4) begin
            lead_owed = 2'd3;
            if (b == 8'hf0) lead_rng = utf8v_pkg::RANGE_90_BF;
            else if (b == 8'hf4) lead_rng = utf8v_pkg::RANGE_80_8F;
         end
         if (b < 8'h20) begin
            verdict.status = utf8v_pkg::ST_ERROR;
         end else if (b <= 8'h7f) begin
            verdict.status      = utf8v_pkg::ST_COMPLETE;
            verdict.char_length = 3'd1;
         end else if (lead_owed == 2'd0 || last) begin
            verdict.status = utf8v_pkg::ST_ERROR;
         end else begin
            owed_count    = lead_owed;
            lead_range    = lead_rng;
            first_pending = 1'b1;
            char_bytes    = {1'b0, lead_owed} + 3'd1;
         end
      end else begin
         rng = first_pending ? lead_range : utf8v_pkg::RANGE_80_BF;
         case (rng)
            utf8v_pkg::RANGE_A0_BF: in_range = (b >= 8'ha0 && b <= 8'hbf);
            utf8v_pkg::RANGE_80_9F: in_range = (b >= 8'h80 && b <= 8'h9f);
            utf8v_pkg::RANGE_90_BF: in_range = (b >= 8'h90 && b <= 8'hbf);
            utf8v_pkg::RANGE_80_8F: in_range = (b >= 8'h80 && b <= 8'h8f);
            default:                in_range = (b[7:6] == 2'b10);
         endcase
         if (!in_range) begin
            verdict.status = utf8v_pkg::ST_ERROR;
         end else begin
            first_pending = 1'b0;
            owed_count    = owed_count - 2'd1;
            if (owed_count == 2'd0) begin
               verdict.status      = utf8v_pkg::ST_COMPLETE;
               verdict.char_length = char_bytes;
            end else if (last) begin
               verdict.status = utf8v_pkg::ST_ERROR;
            end
         end
      end
      // Any finished or rejected sequence drops the tracker back to idle
      if (verdict.status != utf8v_pkg::ST_PENDING) begin
         owed_count    = 2'd0;
         lead_range    = utf8v_pkg::RANGE_80_BF;
         first_pending = 1'b0;
         char_bytes    = 3'd0;
      end
      return verdict;
   endfunction

   // Offer one byte; called and returns at a falling edge
   task automatic send_byte(input logic [7:0] value, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_byte_value <= value;
      req_is_last    <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_verdicts.push_back(judge_byte(value, last));
      bytes_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait out every expected result
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
   endtask

   // Append one well-formed character with random content
   task automatic append_char();
      int         kind;
      int         sel;
      int         tail;
      logic [7:0] lead;
      logic [7:0] lo;
      logic [7:0] hi;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         lead = 8'($urandom_range(8'h20, 8'h7f));
         string_bytes.push_back(lead);
      end else begin
         sel = $urandom_range(0, 3);
         if (kind < 6) begin
            lead = 8'($urandom_range(8'hc2, 8'hdf));
            tail = 0;
         end else if (kind < 8) begin
            lead = (sel == 0) ? 8'he0 : (sel == 1) ? 8'hed :
                   8'($urandom_range(8'he1, 8'hef));
            tail = 1;
         end else begin
            lead = (sel == 0) ? 8'hf0 : (sel == 1) ? 8'hf4 :
                   8'($urandom_range(8'hf1, 8'hf3));
            tail = 2;
         end
         lo = 8'h80;
         hi = 8'hbf;
         if (lead == 8'he0) lo = 8'ha0;
         else if (lead == 8'hed) hi = 8'h9f;
         else if (lead == 8'hf0) lo = 8'h90;
         else if (lead == 8'hf4) hi = 8'h8f;
         string_bytes.push_back(lead);
         string_bytes.push_back(8'($urandom_range(lo, hi)));
         repeat (tail) string_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
      end
   endtask

   // Mostly well-formed strings, some broken, a few pure noise
   task automatic send_random_strings(input int byte_budget);
      int         sent;
      int         pos;
      logic [7:0] junk;
      sent = 0;
      while (sent < byte_budget) begin
         string_bytes.delete();
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 6)) string_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 6)) append_char();
            pos  = $urandom_range(0, string_bytes.size() - 1);
            junk = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 11))
               0: string_bytes[pos] = junk;
               1: begin
                  repeat ($urandom_range(1, 3)) begin
                     if (string_bytes.size() > 1) void'(string_bytes.pop_back());
                  end
               end
               2: string_bytes.insert(pos, junk);
               default: ;
            endcase
         end
         for (int i = 0; i < string_bytes.size(); i++) begin
            send_byte(string_bytes[i], i == string_bytes.size() - 1);
         end
         sent += string_bytes.size();
      end
   endtask

   // Control bytes, printable edges and invalid leads
   task automatic test_single_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'h1f, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h7f, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'hc1, 1'b0);
      send_byte(8'hff, 1'b0);
   endtask

   // Range edges of the first continuation: overlong, surrogate, above U+10FFFF
   task automatic test_multibyte_bounds();
      send_byte(8'hc2, 1'b0);
      send_byte(8'hbf, 1'b0);
      send_byte(8'he0, 1'b0);
      send_byte(8'ha0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'he0, 1'b0);
      send_byte(8'h9f, 1'b0);
      send_byte(8'hed, 1'b0);
      send_byte(8'ha0, 1'b0);
      send_byte(8'hf4, 1'b0);
      send_byte(8'h8f, 1'b0);
      send_byte(8'hbf, 1'b0);
      send_byte(8'hbf, 1'b1);
      send_byte(8'hf4, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'hf0, 1'b0);
      send_byte(8'h8f, 1'b0);
   endtask

   // Cut-off sequences and a bad continuation that must not be rescanned
   task automatic test_truncation_and_recovery();
      send_byte(8'he1, 1'b1);
      send_byte(8'he1, 1'b0);
      send_byte(8'h80, 1'b1);
      send_byte(8'hc2, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h41, 1'b0);
      drain_results();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int budget);
      req_idle_pct = send_pct;
      rsp_idle_pct = recv_pct;
      send_random_strings(budget);
      drain_results();
   endtask

   // Hold the result side long enough for the input to back up
   task automatic test_receiver_hold();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_left    = 64;
      send_random_strings(60);
      drain_results();
   endtask

   // Result side stall: long hold when asked, random otherwise
   initial begin : rsp_stall_driver
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      utf8v_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected result, expected none, got status %0d length %0d",
                     $time, rsp_status, rsp_char_length);
            fail_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, got %0d",
                        $time, want.status, rsp_status);
               fail_count++;
            end
            if (rsp_char_length !== want.char_length) begin
               $display("%0t: char_length mismatch, expected %0d, got %0d",
                        $time, want.char_length, rsp_char_length);
               fail_count++;
            end
            case (want.status)
               utf8v_pkg::ST_COMPLETE: chars_done++;
               utf8v_pkg::ST_ERROR:    bytes_bad++;
               default:                bytes_waiting++;
            endcase
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_verdicts.size());
      $display("tb_utf8_string_byte_validator NOT OK");
      $finish;
   end

   initial begin : run_tests
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_byte_value = 8'h00;
      req_is_last    = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 24;
      rsp_idle_pct = 54;
      test_single_bytes();
      test_multibyte_bounds();
      test_truncation_and_recovery();
      test_random_traffic(24, 54, 500);
      test_random_traffic(54, 24, 500);
      test_receiver_hold();
      test_random_traffic(0, 0, 500);

      drain_results();
      repeat (8) @(posedge clock);
      $display("Checked %0d bytes: %0d characters complete, %0d malformed or truncated,",
               bytes_sent, chars_done, bytes_bad);
      $display("%0d mid-sequence; directed edges, random strings, stalls on both sides.",
               bytes_waiting);
      if (fail_count == 0 && pending_verdicts.size() == 0) begin
         $display("tb_utf8_string_byte_validator OK");
      end else begin
         $display("tb_utf8_string_byte_validator NOT OK");
      end
      $finish;
   end

endmodule
